[design/two_button_debounce_mode_menu_core_assert.svh]
// Assertion macros shared by the debounce and mode menu design.
`ifndef TWO_BUTTON_DEBOUNCE_MODE_MENU_CORE_ASSERT_SVH
`define TWO_BUTTON_DEBOUNCE_MODE_MENU_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TBDM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tbdm assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TBDM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tbdm assertion failed");

`endif

[design/tbdm_pkg.sv]
`timescale 1ns / 1ps

package tbdm_pkg;

    // Width of each saturating debounce timer.
    localparam int TIMER_BITS    = 16;
    // The hold timer is one bit wider than the hold register.
    localparam int HOLD_BITS     = 17;
    localparam int DEBOUNCE_BITS = 10;
    localparam int HOLD_CFG_BITS = 16;
    // Compare width for the debounce timer against its register.
    localparam int DB_CMP_BITS   = (TIMER_BITS > DEBOUNCE_BITS) ? TIMER_BITS : DEBOUNCE_BITS;

    localparam logic [DEBOUNCE_BITS-1:0] DEBOUNCE_RESET = 10'd100;
    localparam logic [HOLD_CFG_BITS-1:0] HOLD_RESET     = 16'd5000;

    localparam logic [1:0] FIRST_CHOICE = 2'd0;
    localparam logic [1:0] LAST_CHOICE  = 2'd2;

    typedef enum logic {
        CFG_DEBOUNCE = 1'b0,
        CFG_HOLD     = 1'b1
    } t_cfg_reg;

    typedef enum logic {
        MODE_NORMAL = 1'b0,
        MODE_MENU   = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        LAMP_KEEP = 2'd0,
        LAMP_ON   = 2'd1,
        LAMP_OFF  = 2'd2
    } t_lamp;

    // Result of the menu logic for one item.
    typedef struct packed {
        logic       level_changed;
        logic       menu_active;
        logic [1:0] choice;
        logic [1:0] role;
        t_lamp      lamp;
    } t_menu_out;

endpackage

[design/tbdm_debounce.sv]
`timescale 1ns / 1ps

// Debounce for one button. State advances once per processed item; the
// outputs show the stable level after the current item.
module tbdm_debounce (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_advance,
    input  logic                                i_raw,
    input  logic [tbdm_pkg::DEBOUNCE_BITS-1:0]  i_debounce_ticks,
    output logic                                o_stable,
    output logic                                o_changed
);

    logic                            r_stable;
    logic                            r_armed;
    logic [tbdm_pkg::TIMER_BITS-1:0] r_timer;
    logic                            n_stable;
    logic                            n_armed;
    logic [tbdm_pkg::TIMER_BITS-1:0] n_timer;

    logic                            diff;
    logic [tbdm_pkg::TIMER_BITS-1:0] timer_inc;
    logic [tbdm_pkg::DB_CMP_BITS-1:0] timer_cmp;
    logic [tbdm_pkg::DB_CMP_BITS-1:0] ticks_cmp;

    always_comb begin
        diff      = (r_stable != i_raw);
        timer_inc = (r_timer == '1) ? r_timer : r_timer + 1'b1;
        // A fresh difference arms the timer from zero.
        n_timer   = (diff && !r_armed) ? '0 : timer_inc;
        n_armed   = r_armed | diff;
        timer_cmp = tbdm_pkg::DB_CMP_BITS'(n_timer);
        ticks_cmp = tbdm_pkg::DB_CMP_BITS'(i_debounce_ticks);
        o_changed = diff && (timer_cmp > ticks_cmp);
        n_stable  = o_changed ? i_raw : r_stable;
        if (o_changed) begin
            n_armed = 1'b0;
        end
        o_stable  = n_stable;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable <= 1'b0;
            r_armed  <= 1'b0;
            r_timer  <= '0;
        end else if (i_advance) begin
            r_stable <= n_stable;
            r_armed  <= n_armed;
            r_timer  <= n_timer;
        end
    end

endmodule

[design/tbdm_menu.sv]
`timescale 1ns / 1ps

// Menu entry, navigation and commit, driven by the debounced levels.
module tbdm_menu (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_advance,
    input  logic                                i_changed,
    input  logic                                i_red,
    input  logic                                i_green,
    input  logic [tbdm_pkg::HOLD_CFG_BITS-1:0]  i_hold_ticks,
    output tbdm_pkg::t_menu_out                 o_result
);

    tbdm_pkg::t_mode                r_mode;
    tbdm_pkg::t_mode                n_mode;
    logic [tbdm_pkg::HOLD_BITS-1:0] r_hold;
    logic [tbdm_pkg::HOLD_BITS-1:0] n_hold;
    logic                           r_entry_armed;
    logic                           n_entry_armed;
    logic                           r_exit_armed;
    logic                           n_exit_armed;
    logic [1:0]                     r_choice;
    logic [1:0]                     n_choice;
    logic [1:0]                     r_role;
    logic [1:0]                     n_role;

    logic                           both;
    logic [tbdm_pkg::HOLD_BITS-1:0] hold_inc;
    logic [tbdm_pkg::HOLD_BITS-1:0] hold_limit;
    logic                           lc;
    tbdm_pkg::t_lamp                lamp;

    always_comb begin
        both          = i_red & i_green;
        hold_inc      = (r_hold == '1) ? r_hold : r_hold + 1'b1;
        hold_limit    = tbdm_pkg::HOLD_BITS'(i_hold_ticks);
        n_mode        = r_mode;
        n_hold        = hold_inc;
        n_entry_armed = r_entry_armed;
        n_exit_armed  = r_exit_armed;
        n_choice      = r_choice;
        n_role        = r_role;
        lc            = 1'b0;
        lamp          = tbdm_pkg::LAMP_KEEP;

        case (r_mode)
            tbdm_pkg::MODE_NORMAL: begin
                lc = i_changed;
                if (i_changed) begin
                    if (both && !r_entry_armed) begin
                        n_entry_armed = 1'b1;
                        n_hold        = '0;
                    end
                    if (!both && r_entry_armed) begin
                        n_entry_armed = 1'b0;
                        if (hold_inc >= hold_limit) begin
                            n_mode       = tbdm_pkg::MODE_MENU;
                            lc           = 1'b0;
                            n_choice     = tbdm_pkg::FIRST_CHOICE;
                            n_exit_armed = 1'b0;
                        end
                    end
                end
                if (both && (n_hold >= hold_limit)) begin
                    lamp = tbdm_pkg::LAMP_ON;
                end
            end
            tbdm_pkg::MODE_MENU: begin
                if (i_changed) begin
                    case ({i_red, i_green})
                        2'b10: begin
                            if (r_exit_armed) begin
                                n_exit_armed = 1'b0;
                            end else begin
                                n_choice = (r_choice == tbdm_pkg::FIRST_CHOICE) ?
                                           tbdm_pkg::LAST_CHOICE : r_choice - 2'd1;
                            end
                        end
                        2'b01: begin
                            if (r_exit_armed) begin
                                n_exit_armed = 1'b0;
                            end else begin
                                n_choice = (r_choice >= tbdm_pkg::LAST_CHOICE) ?
                                           tbdm_pkg::FIRST_CHOICE : r_choice + 2'd1;
                            end
                        end
                        2'b11: begin
                            if (!r_exit_armed) begin
                                n_exit_armed = 1'b1;
                                n_hold       = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                if (n_exit_armed && (n_hold >= hold_limit)) begin
                    n_role       = n_choice;
                    n_mode       = tbdm_pkg::MODE_NORMAL;
                    n_exit_armed = 1'b0;
                    lamp         = both ? tbdm_pkg::LAMP_ON : tbdm_pkg::LAMP_OFF;
                end
            end
            default: begin
                n_mode = tbdm_pkg::MODE_NORMAL;
            end
        endcase

        o_result.level_changed = lc;
        o_result.menu_active   = (n_mode == tbdm_pkg::MODE_MENU);
        o_result.choice        = n_choice;
        o_result.role          = n_role;
        o_result.lamp          = lamp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= tbdm_pkg::MODE_NORMAL;
            r_hold        <= '0;
            r_entry_armed <= 1'b0;
            r_exit_armed  <= 1'b0;
            r_choice      <= tbdm_pkg::FIRST_CHOICE;
            r_role        <= 2'd0;
        end else if (i_advance) begin
            r_mode        <= n_mode;
            r_hold        <= n_hold;
            r_entry_armed <= n_entry_armed;
            r_exit_armed  <= n_exit_armed;
            r_choice      <= n_choice;
            r_role        <= n_role;
        end
    end

endmodule

[design/two_button_debounce_mode_menu_core.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_stall   i_red_raw, i_green_raw
// result    out        o_out_valid / i_out_stall o_red_level .. o_lamp_command
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// Each item waits in the input register and then moves into the result
// register; one item is taken per cycle while the result is not stalled.
// The move from input to result register is the only place the debounce
// and menu state changes. A stalled result blocks the move; the input
// register then fills and the input is stalled. Reset is synchronous and
// active low and restores the register defaults of 100 and 5000 ticks.
module two_button_debounce_mode_menu_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_red_raw,
    input  logic                                i_green_raw,

    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_red_level,
    output logic                                o_green_level,
    output logic                                o_level_changed,
    output logic                                o_menu_active,
    output logic [1:0]                          o_menu_choice,
    output logic [1:0]                          o_role,
    output logic [1:0]                          o_lamp_command,

    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic                                i_cfg_index,
    input  logic [tbdm_pkg::HOLD_CFG_BITS-1:0]  i_cfg_data
);

    `include "two_button_debounce_mode_menu_core_assert.svh"

    // Configuration registers.
    logic [tbdm_pkg::DEBOUNCE_BITS-1:0] r_debounce_ticks;
    logic [tbdm_pkg::HOLD_CFG_BITS-1:0] r_hold_ticks;

    // Input register.
    logic r_in_valid;
    logic r_in_red;
    logic r_in_green;

    // Result register.
    logic                r_out_valid;
    logic                r_out_red;
    logic                r_out_green;
    tbdm_pkg::t_menu_out r_out_menu;

    logic                advance;
    logic                in_accept;
    logic                red_stable;
    logic                green_stable;
    logic                red_changed;
    logic                green_changed;
    tbdm_pkg::t_menu_out menu_result;

    // The held item moves on when the result register is empty or being
    // emptied this cycle.
    assign advance     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !advance;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ticks <= tbdm_pkg::DEBOUNCE_RESET;
            r_hold_ticks     <= tbdm_pkg::HOLD_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (tbdm_pkg::t_cfg_reg'(i_cfg_index))
                tbdm_pkg::CFG_DEBOUNCE: begin
                    r_debounce_ticks <= i_cfg_data[tbdm_pkg::DEBOUNCE_BITS-1:0];
                end
                tbdm_pkg::CFG_HOLD: begin
                    r_hold_ticks <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_red   <= i_red_raw;
            r_in_green <= i_green_raw;
        end
    end

    tbdm_debounce u_red_debounce (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_advance        (advance),
        .i_raw            (r_in_red),
        .i_debounce_ticks (r_debounce_ticks),
        .o_stable         (red_stable),
        .o_changed        (red_changed)
    );

    tbdm_debounce u_green_debounce (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_advance        (advance),
        .i_raw            (r_in_green),
        .i_debounce_ticks (r_debounce_ticks),
        .o_stable         (green_stable),
        .o_changed        (green_changed)
    );

    tbdm_menu u_menu (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_changed    (red_changed | green_changed),
        .i_red        (red_stable),
        .i_green      (green_stable),
        .i_hold_ticks (r_hold_ticks),
        .o_result     (menu_result)
    );

    // Result register: filled on each move, emptied when taken downstream.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_red   <= red_stable;
            r_out_green <= green_stable;
            r_out_menu  <= menu_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_red_level     = r_out_red;
    assign o_green_level   = r_out_green;
    assign o_level_changed = r_out_menu.level_changed;
    assign o_menu_active   = r_out_menu.menu_active;
    assign o_menu_choice   = r_out_menu.choice;
    assign o_role          = r_out_menu.role;
    assign o_lamp_command  = r_out_menu.lamp;

    // A level change is never reported while the menu is shown.
    `TBDM_ASSERT_SAME(a_no_change_in_menu, i_clk, i_rst_n,
        r_out_valid && r_out_menu.level_changed, !r_out_menu.menu_active)
    // Lamps off is only commanded on the commit tick, which leaves the menu.
    `TBDM_ASSERT_SAME(a_lamp_off_leaves_menu, i_clk, i_rst_n,
        r_out_valid && (r_out_menu.lamp == tbdm_pkg::LAMP_OFF), !r_out_menu.menu_active)
    // Every item that moves on shows up in the result register.
    `TBDM_ASSERT_NEXT(a_advance_fills_result, i_clk, i_rst_n, advance, r_out_valid)
    // The input is only stalled while an item sits in the input register.
    `TBDM_ASSERT_SAME(a_stall_needs_item, i_clk, i_rst_n, o_in_stall, r_in_valid)

endmodule

[bench/two_button_debounce_mode_menu_core_tb.sv]
`timescale 1ns / 1ps

module two_button_debounce_mode_menu_core_tb;

    import tbdm_pkg::*;

    // Cycles in a row with no item moving on any channel before the run is
    // declared hung. Even at the heaviest idling items move often enough that
    // this leaves a wide margin.
    localparam int QUIET_LIMIT = 2000;
    // Random ticks per register setting. Each setting runs as two halves,
    // and the sender waits for every result between them.
    localparam int PHASE_TICKS = 160;
    // Chance, in percent, of an idle cycle on one side.
    localparam int IDLE_HEAVY  = 78;
    localparam int IDLE_SHARED = 34;
    localparam int BTN_RED     = 0;
    localparam int BTN_GREEN   = 1;

    // How the two sides of the item channels idle during a phase.
    typedef enum logic [1:0] {
        PACE_FULL,
        PACE_SENDER,
        PACE_RECEIVER,
        PACE_BOTH
    } t_pace;

    // Raw button levels of one millisecond tick.
    typedef struct packed {
        logic red;
        logic green;
    } t_press;

    // Everything the block reports after one tick.
    typedef struct packed {
        logic       red;
        logic       green;
        logic       changed;
        logic       in_menu;
        logic [1:0] choice;
        logic [1:0] role;
        t_lamp      lamp;
    } t_panel;

    logic                     i_clk           = 1'b0;
    logic                     i_rst_n         = 1'b0;
    logic                     i_in_valid      = 1'b0;
    logic                     i_red_raw       = 1'b0;
    logic                     i_green_raw     = 1'b0;
    logic                     i_out_stall     = 1'b0;
    logic                     i_cfg_valid     = 1'b0;
    logic                     i_cfg_index     = 1'b0;
    logic [HOLD_CFG_BITS-1:0] i_cfg_data      = '0;
    logic                     o_in_stall;
    logic                     o_out_valid;
    logic                     o_red_level;
    logic                     o_green_level;
    logic                     o_level_changed;
    logic                     o_menu_active;
    logic [1:0]               o_menu_choice;
    logic [1:0]               o_role;
    logic [1:0]               o_lamp_command;
    logic                     o_cfg_ready;

    two_button_debounce_mode_menu_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_red_raw       (i_red_raw),
        .i_green_raw     (i_green_raw),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_red_level     (o_red_level),
        .o_green_level   (o_green_level),
        .o_level_changed (o_level_changed),
        .o_menu_active   (o_menu_active),
        .o_menu_choice   (o_menu_choice),
        .o_role          (o_role),
        .o_lamp_command  (o_lamp_command),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Ticks waiting to be offered, and the panel states predicted for the
    // ticks the block has taken but not yet answered, oldest first.
    t_press pending_ticks [$];
    t_panel panel_expect_q [$];
    int     ticks_queued = 0;
    int     err_count    = 0;
    int     quiet_cycles = 0;
    bit     tick_taken   = 1'b0;
    t_pace  pace         = PACE_FULL;

    // Our own copy of the block's registers and state, at reset values.
    logic [DEBOUNCE_BITS-1:0] db_cfg   = DEBOUNCE_RESET;
    logic [HOLD_CFG_BITS-1:0] hold_cfg = HOLD_RESET;
    logic                     btn_stable [2] = '{1'b0, 1'b0};
    logic                     btn_armed  [2] = '{1'b0, 1'b0};
    logic [TIMER_BITS-1:0]    btn_tmr    [2] = '{'0, '0};
    logic [HOLD_BITS-1:0]     hold_tmr    = '0;
    logic                     entry_armed = 1'b0;
    logic                     exit_armed  = 1'b0;
    t_mode                    mode        = MODE_NORMAL;
    logic [1:0]               sel         = FIRST_CHOICE;
    logic [1:0]               role_q      = FIRST_CHOICE;

    // Debounces one button. A level that differs from the stable one arms
    // the timer once; the flag is not dropped if the raw level returns, so a
    // later difference may be taken at once. Returns 1 on an accepted change.
    function automatic logic settle_button(input int b, input logic raw);
        if (btn_stable[b] != raw && !btn_armed[b]) begin
            btn_armed[b] = 1'b1;
            btn_tmr[b]   = '0;
        end
        if (btn_stable[b] != raw && btn_armed[b] && btn_tmr[b] > db_cfg) begin
            btn_stable[b] = raw;
            btn_armed[b]  = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Advances the panel by one tick and returns what the block must report.
    function automatic t_panel advance_panel(input logic r, input logic g);
        t_panel res;
        logic   chg_r;
        logic   chg_g;
        logic   chg;
        logic   both;
        res.lamp    = LAMP_KEEP;
        res.changed = 1'b0;
        // All timers count first, saturating at their full width.
        for (int b = 0; b < 2; b++) begin
            if (btn_tmr[b] != '1) btn_tmr[b] = btn_tmr[b] + 1'b1;
        end
        if (hold_tmr != '1) hold_tmr = hold_tmr + 1'b1;

        chg_r = settle_button(BTN_RED, r);
        chg_g = settle_button(BTN_GREEN, g);
        chg   = chg_r | chg_g;
        both  = btn_stable[BTN_RED] && btn_stable[BTN_GREEN];

        if (mode == MODE_NORMAL) begin
            res.changed = chg;
            if (chg) begin
                // Both down starts the long hold; letting one go after the
                // hold has run opens the menu at the first choice.
                if (both && !entry_armed) begin
                    entry_armed = 1'b1;
                    hold_tmr    = '0;
                end
                if (!both && entry_armed) begin
                    entry_armed = 1'b0;
                    if (hold_tmr >= hold_cfg) begin
                        mode        = MODE_MENU;
                        res.changed = 1'b0;
                        sel         = FIRST_CHOICE;
                        exit_armed  = 1'b0;
                    end
                end
            end
            if (both && hold_tmr >= hold_cfg) res.lamp = LAMP_ON;
        end else begin
            if (chg) begin
                // A single button moves the choice, unless it cancels an
                // armed exit; both down arms the exit and restarts the hold.
                if (btn_stable[BTN_RED] && !btn_stable[BTN_GREEN]) begin
                    if (exit_armed) exit_armed = 1'b0;
                    else sel = (sel == FIRST_CHOICE) ? LAST_CHOICE : sel - 2'd1;
                end else if (btn_stable[BTN_GREEN] && !btn_stable[BTN_RED]) begin
                    if (exit_armed) exit_armed = 1'b0;
                    else sel = (sel >= LAST_CHOICE) ? FIRST_CHOICE : sel + 2'd1;
                end else if (both && !exit_armed) begin
                    exit_armed = 1'b1;
                    hold_tmr   = '0;
                end
            end
            // An armed exit commits once the hold has run, even if both
            // buttons were let go in the meantime.
            if (exit_armed && hold_tmr >= hold_cfg) begin
                role_q     = sel;
                mode       = MODE_NORMAL;
                exit_armed = 1'b0;
                if (both) res.lamp = LAMP_ON;
                else res.lamp = LAMP_OFF;
            end
        end

        res.red     = btn_stable[BTN_RED];
        res.green   = btn_stable[BTN_GREEN];
        res.in_menu = (mode == MODE_MENU);
        res.choice  = sel;
        res.role    = role_q;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        err_count++;
        $display("mismatch %0d at %0t: %s", err_count, $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [1:0] got,
                               input logic [1:0] want);
        if (got !== want) report_mismatch($sformatf("%s is %b, expected %b", name, got, want));
    endtask

    function automatic int idle_pct(input bit is_sender);
        case (pace)
            PACE_SENDER:   return is_sender ? IDLE_HEAVY : 0;
            PACE_RECEIVER: return is_sender ? 0 : IDLE_HEAVY;
            PACE_BOTH:     return IDLE_SHARED;
            default:       return 0;
        endcase
    endfunction

    // Queues n ticks at the given levels. A bouncy run starts with a burst
    // of random levels no longer than the debounce time, which exercises
    // early returns and chatter on the way to the settled level.
    task automatic queue_levels(input logic r, input logic g, input int n, input bit bouncy);
        int chatter;
        chatter = bouncy ? $urandom_range(0, db_cfg + 1) : 0;
        for (int i = 0; i < n; i++) begin
            if (i < chatter) pending_ticks.push_back(t_press'(2'($urandom_range(0, 3))));
            else pending_ticks.push_back(t_press'({r, g}));
            ticks_queued++;
        end
    endtask

    // Long enough for a level to be accepted, now and then too short.
    function automatic int settle_len();
        if ($urandom_range(0, 5) == 0) return $urandom_range(1, db_cfg + 1);
        return db_cfg + 2 + $urandom_range(0, 3);
    endfunction

    // Long enough to debounce and then run out the hold, now and then short.
    function automatic int hold_len();
        if ($urandom_range(0, 4) == 0) return $urandom_range(1, db_cfg + hold_cfg + 1);
        return db_cfg + hold_cfg + 2 + $urandom_range(0, 4);
    endfunction

    // A full trip through the menu: long hold on both, release into the
    // menu, a few single presses, then one of three ways out.
    task automatic queue_menu_session();
        int   moves;
        logic red_only;
        queue_levels(1'b1, 1'b1, hold_len(), 1'($urandom_range(0, 1)));
        case ($urandom_range(0, 2))
            0:       queue_levels(1'b1, 1'b0, settle_len(), 1'($urandom_range(0, 1)));
            1:       queue_levels(1'b0, 1'b1, settle_len(), 1'($urandom_range(0, 1)));
            default: queue_levels(1'b0, 1'b0, settle_len(), 1'($urandom_range(0, 1)));
        endcase
        moves = $urandom_range(0, 5);
        repeat (moves) begin
            red_only = 1'($urandom_range(0, 1));
            queue_levels(red_only, !red_only, settle_len(), 1'($urandom_range(0, 1)));
            queue_levels(1'b0, 1'b0, settle_len(), 1'($urandom_range(0, 1)));
        end
        red_only = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
            0: begin
                // Arm the exit, cancel it with one button, then arm again.
                queue_levels(1'b1, 1'b1, settle_len(), 1'b0);
                queue_levels(red_only, !red_only, settle_len(), 1'b0);
                queue_levels(1'b1, 1'b1, hold_len(), 1'b0);
            end
            1: begin
                // Arm the exit and let both go before the hold has run.
                queue_levels(1'b1, 1'b1, settle_len(), 1'b0);
                queue_levels(1'b0, 1'b0, hold_len(), 1'b0);
            end
            default: queue_levels(1'b1, 1'b1, hold_len(), 1'($urandom_range(0, 1)));
        endcase
        queue_levels(1'b0, 1'b0, settle_len(), 1'($urandom_range(0, 1)));
    endtask

    // Returns on a rising edge once every tick has been offered, taken and
    // answered, so the block is idle. The check sits on the rising edge so
    // that a tick popped by the sender on the falling edge already shows
    // up on the valid line.
    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_ticks.size() != 0 || i_in_valid || panel_expect_q.size() != 0);
    endtask

    // Writes one register and updates our copy once the block has taken it.
    task automatic cfg_write(input t_cfg_reg idx, input logic [HOLD_CFG_BITS-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        if (idx == CFG_DEBOUNCE) db_cfg = data[DEBOUNCE_BITS-1:0];
        else hold_cfg = data;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // One register setting: write both registers on an idle block, then
    // two halves of random traffic with a full drain after each.
    task automatic run_phase(input logic [DEBOUNCE_BITS-1:0] db,
                             input logic [HOLD_CFG_BITS-1:0] hold, input t_pace p);
        int target;
        wait_drained();
        cfg_write(CFG_DEBOUNCE, HOLD_CFG_BITS'(db));
        cfg_write(CFG_HOLD, hold);
        pace = p;
        repeat (2) begin
            target = ticks_queued + PHASE_TICKS / 2;
            while (ticks_queued < target) begin
                if ($urandom_range(0, 9) < 7) begin
                    queue_menu_session();
                end else begin
                    queue_levels(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                 $urandom_range(1, db_cfg + hold_cfg + 4),
                                 1'($urandom_range(0, 1)));
                end
            end
            wait_drained();
        end
    endtask

    // Sender side. On each falling edge the current item is kept until the
    // block takes it; a new one is offered only when the slot is free and
    // the random idle draw allows. Valid never looks at the stall.
    always @(negedge i_clk) begin : feed_ticks
        logic   vld;
        t_press nxt;
        vld = i_in_valid;
        nxt = t_press'({i_red_raw, i_green_raw});
        if (tick_taken) vld = 1'b0;
        tick_taken = 1'b0;
        if (!vld && i_rst_n && pending_ticks.size() != 0
                && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
            nxt = pending_ticks.pop_front();
            vld = 1'b1;
        end else if (!vld) begin
            // Idle cycles carry random levels that must be ignored.
            nxt = t_press'(2'($urandom_range(0, 3)));
        end
        i_in_valid  <= vld;
        i_red_raw   <= nxt.red;
        i_green_raw <= nxt.green;
    end

    // Receiver side: random stall, changed only on falling edges.
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < idle_pct(1'b0));
    end

    // Both item channels are watched here at the rising edge. The result is
    // checked before the tick taken at the same edge is predicted, so the
    // store is always used oldest first.
    always @(posedge i_clk) begin : watch_panel
        t_panel want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (panel_expect_q.size() == 0) begin
                report_mismatch("result arrived with no tick outstanding");
            end else begin
                want = panel_expect_q.pop_front();
                check_field("red_level", o_red_level, want.red);
                check_field("green_level", o_green_level, want.green);
                check_field("level_changed", o_level_changed, want.changed);
                check_field("menu_active", o_menu_active, want.in_menu);
                check_field("menu_choice", o_menu_choice, want.choice);
                check_field("role", o_role, want.role);
                check_field("lamp_command", o_lamp_command, want.lamp);
            end
        end
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            panel_expect_q.push_back(advance_panel(i_red_raw, i_green_raw));
            tick_taken = 1'b1;
        end
    end

    // Ends a hung run: counts cycles in which no channel moves anything.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // A few ticks on the reset register values, one per level pair.
        queue_levels(1'b1, 1'b1, 1, 1'b0);
        queue_levels(1'b1, 1'b0, 1, 1'b0);
        queue_levels(1'b0, 1'b1, 1, 1'b0);
        queue_levels(1'b0, 1'b0, 1, 1'b0);
        wait_drained();

        // Directed walk with a zero debounce register and a short hold: the lamp
        // on a long hold, the entry tick, a release and a move inside the
        // menu, an exit cancelled by one button, and an exit that commits
        // after both buttons were let go, then a plain change outside.
        cfg_write(CFG_DEBOUNCE, 16'd0);
        cfg_write(CFG_HOLD, 16'd3);
        queue_levels(1'b1, 1'b1, 5, 1'b0);
        queue_levels(1'b1, 1'b0, 2, 1'b0);
        queue_levels(1'b0, 1'b0, 2, 1'b0);
        queue_levels(1'b0, 1'b1, 2, 1'b0);
        queue_levels(1'b1, 1'b1, 2, 1'b0);
        queue_levels(1'b0, 1'b1, 2, 1'b0);
        queue_levels(1'b1, 1'b1, 2, 1'b0);
        queue_levels(1'b0, 1'b0, 3, 1'b0);
        queue_levels(1'b1, 1'b0, 2, 1'b0);
        wait_drained();

        // Largest register values: no change can settle in this short run.
        cfg_write(CFG_DEBOUNCE, 16'd1023);
        cfg_write(CFG_HOLD, 16'd65535);
        pace = PACE_BOTH;
        repeat (12) begin
            queue_levels(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         $urandom_range(1, 6), 1'b0);
        end

        // Random traffic over several settings, zero registers among them,
        // and every idling pattern.
        run_phase(10'd1, 16'd1, PACE_FULL);
        run_phase(10'd2, 16'd12, PACE_SENDER);
        run_phase(10'd0, 16'd0, PACE_RECEIVER);
        run_phase(10'd3, 16'd20, PACE_BOTH);
        run_phase(10'd1, 16'd6, PACE_FULL);

        // After the drain, keep watching for any stray result.
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+design
design/tbdm_pkg.sv
design/tbdm_debounce.sv
design/tbdm_menu.sv
design/two_button_debounce_mode_menu_core.sv
bench/two_button_debounce_mode_menu_core_tb.sv
